@@ hw/rtl/mjrt_pkg.sv @@
// ----------------------------------------------------------------------------
// mjrt_pkg
// Shared types and constants of the minimum-jerk reference tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mjrt_pkg;

  // Normalized time and its powers are Q.30
  localparam int TAU_BITS    = 30;
  localparam int PROD_W      = 64;   // elapsed * inv_duration, Q32.32
  localparam int T_W         = 31;   // tau and its powers, up to 1.0 in Q.30
  localparam int SHAPE_W     = 34;   // signed velocity shape sum
  localparam int SHAPE_MAG_W = 32;   // magnitude of the shape, at most 2^31
  localparam int BLEND_W     = 36;   // signed position blend sum
  localparam int BLEND_MAG_W = 34;   // magnitude of the blend, below 2^34

  // tau above one ends the trajectory
  localparam logic [PROD_W-1:0] TAU_ONE = PROD_W'(64'h1_0000_0000);

  // Polynomial coefficients
  localparam logic [BLEND_W-1:0] K_BLEND3 = BLEND_W'(10);
  localparam logic [BLEND_W-1:0] K_BLEND4 = BLEND_W'(15);
  localparam logic [BLEND_W-1:0] K_BLEND5 = BLEND_W'(6);
  localparam logic [SHAPE_W-1:0] K_SHAPE3 = SHAPE_W'(2);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_START_TIME    = 3'd0,
    REG_INV_DURATION  = 3'd1,
    REG_RATE_SCALE    = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_INITIAL_ERROR = 3'd4,
    REG_ERROR_CHANGE  = 3'd5
  } cfg_reg_t;

  // Result of the power chain, one item
  typedef struct packed {
    logic                   fin;
    logic [T_W-1:0]         t3;
    logic [T_W-1:0]         t4;
    logic [T_W-1:0]         t5;
    logic                   shape_neg;
    logic [SHAPE_MAG_W-1:0] shape_mag;
  } pow_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/mjrt_power_chain.sv @@
// ----------------------------------------------------------------------------
// mjrt_power_chain
// Four-stage chain that forms tau, t^2..t^5 and the signed velocity shape.
// ----------------------------------------------------------------------------
`default_nettype none

module mjrt_power_chain
  import mjrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [PROD_W-1:0] prod,
  output pow_out_t               pw
);

  // One Q.30 power step, truncated
  function automatic logic [T_W-1:0] pow_step(input logic [T_W-1:0] x,
                                              input logic [T_W-1:0] t);
    logic [2*T_W-1:0] p;
    p = (2*T_W)'(x) * (2*T_W)'(t);
    return p[TAU_BITS+T_W-1:TAU_BITS];
  endfunction

  logic [T_W-1:0] tau;
  logic [T_W-1:0] t_a_r, t2_a_r;
  logic           fin_a_r;
  logic [T_W-1:0] t_b_r, t2_b_r, t3_b_r;
  logic           fin_b_r;
  logic [T_W-1:0] t_c_r, t2_c_r, t3_c_r, t4_c_r;
  logic           fin_c_r;
  logic signed [SHAPE_W-1:0] shape;
  logic [SHAPE_W-1:0]        shape_abs;
  pow_out_t       pw_nxt, pw_r;

  assign tau = prod[T_W+1:2];

  // Stage A: end test and t^2
  always_ff @(posedge clk) begin
    if (en) begin
      fin_a_r <= (prod > TAU_ONE);
      t_a_r   <= tau;
      t2_a_r  <= pow_step(tau, tau);
    end
  end

  // Stage B: t^3
  always_ff @(posedge clk) begin
    if (en) begin
      fin_b_r <= fin_a_r;
      t_b_r   <= t_a_r;
      t2_b_r  <= t2_a_r;
      t3_b_r  <= pow_step(t2_a_r, t_a_r);
    end
  end

  // Stage C: t^4
  always_ff @(posedge clk) begin
    if (en) begin
      fin_c_r <= fin_b_r;
      t_c_r   <= t_b_r;
      t2_c_r  <= t2_b_r;
      t3_c_r  <= t3_b_r;
      t4_c_r  <= pow_step(t3_b_r, t_b_r);
    end
  end

  // Stage D: t^5 and the shape t^2 - 2t^3 + t^4 as sign and magnitude
  always_comb begin
    shape     = $signed(SHAPE_W'(t2_c_r) - K_SHAPE3 * SHAPE_W'(t3_c_r)
                        + SHAPE_W'(t4_c_r));
    shape_abs = shape[SHAPE_W-1] ? SHAPE_W'(-shape) : SHAPE_W'(shape);
    pw_nxt.fin       = fin_c_r;
    pw_nxt.t3        = t3_c_r;
    pw_nxt.t4        = t4_c_r;
    pw_nxt.t5        = pow_step(t4_c_r, t_c_r);
    pw_nxt.shape_neg = shape[SHAPE_W-1];
    pw_nxt.shape_mag = shape_abs[SHAPE_MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw_r <= pw_nxt;
    end
  end

  assign pw = pw_r;

endmodule

`default_nettype wire

@@ hw/rtl/minimal_jerk_reference_tracker.sv @@
// ----------------------------------------------------------------------------
// minimal_jerk_reference_tracker
// Minimum-jerk quintic reference with proportional error feedback, one axis.
// ----------------------------------------------------------------------------
// Takes one request per cycle while no result waits at the output and passes
// it through a chain of registered multipliers (the Q32.32 time product, four
// power steps, then the shape, blend, forward and feedback products). The
// whole pipeline advances together and holds when a finished result waits
// at the output, so a stall costs no items. The user writes configuration
// through the cfg port only while no request is in flight; the block does not
// enforce this. cfg_ready is always high and indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module minimal_jerk_reference_tracker
  import mjrt_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [31:0] sample_time, [63:32] measured_error
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  // out_tdata: [31:0] rate_command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  // out_tuser: [0] finished
  output logic [0:0]       out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);

  localparam int NSTAGE     = 12;
  localparam int FWD_PROD_W = 65;                  // 32 x 33
  localparam int FWD_MAG_W  = FWD_PROD_W - FRACTION_BITS;
  localparam int FWD_W      = FWD_MAG_W + 1;
  localparam int BL_PROD_W  = 32 + BLEND_MAG_W;
  localparam int BL_MAG_W   = 35;
  localparam int TGT_W      = 37;
  localparam int DIFF_W     = 38;
  localparam int DMAG_W     = 37;
  localparam int DHI_W      = DMAG_W - 32;
  localparam int FB_PROD_W  = DMAG_W + 32;
  localparam int FB_MAG_W   = FB_PROD_W - FRACTION_BITS;
  localparam int FB_W       = FB_MAG_W + 1;
  localparam int CMD_W      = FB_W + 1;
  localparam int RS_MAG_W   = 33;

  // Configuration registers
  logic [31:0]        start_time_r, inv_duration_r, rate_scale_r, feedback_gain_r;
  logic signed [31:0] initial_error_r;
  logic               change_neg_r;
  logic [31:0]        change_mag_r;
  logic [31:0]        cfg_abs;

  // Pipeline control
  logic              en;
  logic [NSTAGE-1:0] vld_r;
  logic              out_vld_r;

  // Stage registers
  logic [PROD_W-1:0]      prod_r;
  logic signed [31:0]     meas_r [9];
  pow_out_t               pw;
  logic                   fin_r [7];
  logic signed [BLEND_W-1:0] blend_r;
  logic [63:0]            rs_prod_r;
  logic                   rs_neg_r;
  logic [BLEND_MAG_W-1:0] bl_mag_r;
  logic                   bl_neg_r;
  logic [RS_MAG_W-1:0]    rs_mag_r;
  logic                   fwd_neg_r;
  logic [BL_PROD_W-1:0]   bl_prod_r;
  logic [FWD_PROD_W-1:0]  fwd_prod_r;
  logic                   bl_neg8_r, fwd_neg8_r;
  logic signed [TGT_W-1:0] target_r;
  logic signed [FWD_W-1:0] fwd_r [4];
  logic [DMAG_W-1:0]      dmag_r;
  logic                   dneg_r;
  logic [63:0]            fb_lo_r;
  logic [DHI_W+31:0]      fb_hi_r;
  logic                   fb_neg_r;
  logic signed [FB_W-1:0] fb_r;
  logic [31:0]            cmd_r;
  logic                   done_r;

  // Combinational stage values
  logic [31:0]               elapsed;
  logic signed [BLEND_W-1:0] blend_nxt;
  logic [BLEND_W-1:0]        blend_abs;
  logic signed [BL_MAG_W:0]  bl_term;
  logic signed [FWD_W-1:0]   fwd_nxt;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_abs;
  logic [FB_PROD_W-1:0]      fb_sum;
  logic signed [FB_W-1:0]    fb_nxt;
  logic signed [CMD_W-1:0]   cmd;
  logic [31:0]               cmd_sat;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // Write configuration; keep the magnitude of error_change ready for the
  // multipliers
  assign cfg_abs = cfg_data[31] ? (32'd0 - cfg_data) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r    <= '0;
      inv_duration_r  <= '0;
      rate_scale_r    <= '0;
      feedback_gain_r <= '0;
      initial_error_r <= '0;
      change_neg_r    <= 1'b0;
      change_mag_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_TIME:    start_time_r    <= cfg_data;
        REG_INV_DURATION:  inv_duration_r  <= cfg_data;
        REG_RATE_SCALE:    rate_scale_r    <= cfg_data;
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data;
        REG_INITIAL_ERROR: initial_error_r <= $signed(cfg_data);
        REG_ERROR_CHANGE: begin
          change_neg_r <= cfg_data[31];
          change_mag_r <= cfg_abs;
        end
        default: ;
      endcase
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NSTAGE-2:0], in_tvalid};
      out_vld_r <= vld_r[NSTAGE-1];
    end
  end

  // Stage 1: elapsed time times inverse duration
  assign elapsed = in_tdata[31:0] - start_time_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(elapsed) * PROD_W'(inv_duration_r);
    end
  end

  // Carry the measured error until the feedback difference
  always_ff @(posedge clk) begin
    if (en) begin
      meas_r[0] <= $signed(in_tdata[63:32]);
      for (int i = 1; i < 9; i++) begin
        meas_r[i] <= meas_r[i-1];
      end
    end
  end

  // Stages 2 to 5: powers of tau and the velocity shape
  mjrt_power_chain u_power_chain (
    .clk  (clk),
    .en   (en),
    .prod (prod_r),
    .pw   (pw)
  );

  // Carry the end flag to the output
  always_ff @(posedge clk) begin
    if (en) begin
      fin_r[0] <= pw.fin;
      for (int i = 1; i < 7; i++) begin
        fin_r[i] <= fin_r[i-1];
      end
    end
  end

  // Stage 6: blend sum and rate_scale times shape
  assign blend_nxt = $signed(K_BLEND3 * BLEND_W'(pw.t3) - K_BLEND4 * BLEND_W'(pw.t4)
                             + K_BLEND5 * BLEND_W'(pw.t5));

  always_ff @(posedge clk) begin
    if (en) begin
      blend_r   <= blend_nxt;
      rs_prod_r <= 64'(rate_scale_r) * 64'(pw.shape_mag);
      rs_neg_r  <= pw.shape_neg;
    end
  end

  // Stage 7: magnitudes and signs of the blend and scaled shape terms
  assign blend_abs = blend_r[BLEND_W-1] ? BLEND_W'(-blend_r) : BLEND_W'(blend_r);

  always_ff @(posedge clk) begin
    if (en) begin
      bl_mag_r  <= blend_abs[BLEND_MAG_W-1:0];
      bl_neg_r  <= blend_r[BLEND_W-1] ^ change_neg_r;
      rs_mag_r  <= rs_prod_r[TAU_BITS+RS_MAG_W-1:TAU_BITS];
      fwd_neg_r <= rs_neg_r ^ change_neg_r;
    end
  end

  // Stage 8: error_change times blend and times scaled shape
  always_ff @(posedge clk) begin
    if (en) begin
      bl_prod_r  <= BL_PROD_W'(change_mag_r) * BL_PROD_W'(bl_mag_r);
      fwd_prod_r <= FWD_PROD_W'(change_mag_r) * FWD_PROD_W'(rs_mag_r);
      bl_neg8_r  <= bl_neg_r;
      fwd_neg8_r <= fwd_neg_r;
    end
  end

  // Stage 9: target error and feed-forward term
  always_comb begin
    bl_term = $signed({1'b0, bl_prod_r[TAU_BITS+BL_MAG_W-1:TAU_BITS]});
    if (bl_neg8_r) begin
      bl_term = -bl_term;
    end
    fwd_nxt = $signed({1'b0, fwd_prod_r[FWD_PROD_W-1:FRACTION_BITS]});
    if (fwd_neg8_r) begin
      fwd_nxt = -fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      target_r <= TGT_W'(initial_error_r) + TGT_W'(bl_term);
      fwd_r[0] <= fwd_nxt;
      for (int i = 1; i < 4; i++) begin
        fwd_r[i] <= fwd_r[i-1];
      end
    end
  end

  // Stage 10: tracking difference as sign and magnitude
  assign diff     = DIFF_W'(meas_r[8]) - DIFF_W'(target_r);
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      dmag_r <= diff_abs[DMAG_W-1:0];
      dneg_r <= diff[DIFF_W-1];
    end
  end

  // Stage 11: gain times difference, split into two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      fb_lo_r  <= 64'(dmag_r[31:0]) * 64'(feedback_gain_r);
      fb_hi_r  <= (DHI_W+32)'(dmag_r[DMAG_W-1:32]) * (DHI_W+32)'(feedback_gain_r);
      fb_neg_r <= dneg_r;
    end
  end

  // Stage 12: combine partial products into the signed feedback term
  always_comb begin
    fb_sum = {fb_hi_r, 32'd0} + FB_PROD_W'(fb_lo_r);
    fb_nxt = $signed({1'b0, fb_sum[FB_PROD_W-1:FRACTION_BITS]});
    if (fb_neg_r) begin
      fb_nxt = -fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fb_r <= fb_nxt;
    end
  end

  // Output: forward minus feedback, saturated; zero once finished
  always_comb begin
    cmd = CMD_W'(fwd_r[3]) - CMD_W'(fb_r);
    if ((&cmd[CMD_W-1:31]) || !(|cmd[CMD_W-1:31])) begin
      cmd_sat = cmd[31:0];
    end else if (cmd[CMD_W-1]) begin
      cmd_sat = 32'h8000_0000;
    end else begin
      cmd_sat = 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r  <= fin_r[6] ? 32'd0 : cmd_sat;
      done_r <= fin_r[6];
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = cmd_r;
  assign out_tuser[0] = done_r;

  // A finished result carries a zero command
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("finished result with nonzero command");

  // A waiting result blocks new requests
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request accepted while result waits");

  // An accepted request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request lost at stage one");

  // A held pipeline keeps its valid bits
  a_hold_vld: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

endmodule

`default_nettype wire

@@ test/tb_minimal_jerk_reference_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_minimal_jerk_reference_tracker
// Self-checking bench for the minimum-jerk reference tracker.
// ----------------------------------------------------------------------------
// Drives sample requests through the stream input and loads trajectories
// through the cfg port between bursts. A scoreboard predicts each commanded
// rate and finished flag in Q16.16 and checks the output stream in order.
// Directed requests cover the reset state, tau at zero, one half, exactly one
// and just past one, time wrap before the start, saturation in both
// directions and a zero inverse duration. Random bursts follow under several
// trajectories with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_minimal_jerk_reference_tracker;
  import mjrt_pkg::*;

  localparam int FRAC        = 16;
  localparam int PIPE_DEPTH  = 13;
  localparam int STALL_LIMIT = 5000;
  localparam int SEG_ITEMS   = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [31:0] rate;
    logic        fin;
  } command_t;

  // Predict the commanded rate and compare against the output stream
  class tracker_checker;
    bit [31:0] start_time, inv_duration, rate_scale;
    bit [31:0] feedback_gain, initial_error, error_change;
    command_t  pending[$];
    int        failures;

    function void set_reg(bit [2:0] idx, bit [31:0] v);
      case (idx)
        REG_START_TIME:    start_time    = v;
        REG_INV_DURATION:  inv_duration  = v;
        REG_RATE_SCALE:    rate_scale    = v;
        REG_FEEDBACK_GAIN: feedback_gain = v;
        REG_INITIAL_ERROR: initial_error = v;
        REG_ERROR_CHANGE:  error_change  = v;
        default: ;
      endcase
    endfunction

    function bit [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // sign(a*b) * floor(|a|*|b| / 2^s), split to stay inside 64 bits
    function longint scaled_product(longint a, longint b, int s);
      bit [63:0] ma, mb, low_mask, r;
      ma = magnitude(a);
      mb = magnitude(b);
      low_mask = (64'd1 << s) - 64'd1;
      r = mb * (ma >> s) + ((mb * (ma & low_mask)) >> s);
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function command_t command_for(bit [31:0] now, bit [31:0] meas_bits);
      command_t  c;
      bit [31:0] elapsed;
      bit [63:0] prod, t, t2, t3, t4, t5;
      longint    blend, shape, meas, init, change, target;
      longint    rate_shape, forward, feedback, cmd;
      elapsed = now - start_time;
      prod = {32'd0, elapsed} * {32'd0, inv_duration};
      if (prod > 64'h1_0000_0000) begin
        c.rate = 32'd0;
        c.fin  = 1'b1;
        return c;
      end
      // Powers of tau in Q.30
      t  = prod >> 2;
      t2 = (t * t) >> TAU_BITS;
      t3 = (t2 * t) >> TAU_BITS;
      t4 = (t3 * t) >> TAU_BITS;
      t5 = (t4 * t) >> TAU_BITS;
      blend = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
      shape = longint'(t2) - 2 * longint'(t3) + longint'(t4);
      meas   = longint'($signed(meas_bits));
      init   = longint'($signed(initial_error));
      change = longint'($signed(error_change));
      target     = init + scaled_product(change, blend, TAU_BITS);
      rate_shape = scaled_product(longint'({32'd0, rate_scale}), shape, TAU_BITS);
      forward    = scaled_product(change, rate_shape, FRAC);
      feedback   = scaled_product(meas - target, longint'({32'd0, feedback_gain}), FRAC);
      cmd = forward - feedback;
      if (cmd > 64'sd2147483647) cmd = 64'sd2147483647;
      if (cmd < -64'sd2147483648) cmd = -64'sd2147483648;
      c.rate = cmd[31:0];
      c.fin  = 1'b0;
      return c;
    endfunction

    function void note_sample(bit [31:0] now, bit [31:0] meas_bits);
      pending.push_back(command_for(now, meas_bits));
    endfunction

    function void check_command(logic [31:0] rate, logic fin);
      command_t exp_cmd;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: rate=%h finished=%b", rate, fin);
        return;
      end
      exp_cmd = pending.pop_front();
      if (rate !== exp_cmd.rate || fin !== exp_cmd.fin) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected rate=%h finished=%b, got rate=%h finished=%b",
                   exp_cmd.rate, exp_cmd.fin, rate, fin);
      end
    endfunction

    function void close();
      failures += pending.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = 64'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  tracker_checker chk = new;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit pressure_pending = 1'b0;
  bit pressure_done = 1'b0;
  int hold_count = 0;
  int stall_cycles = 0;
  bit unused_pick = 1'b0;

  // Current trajectory for random bursts
  bit [31:0] traj_start, traj_inv, traj_rate, traj_gain, traj_init, traj_change;
  int unsigned traj_span;

  minimal_jerk_reference_tracker #(.FRACTION_BITS(FRAC)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Accept results, idle at random and hold off once for a long stretch
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      chk.check_command(out_tdata, out_tuser[0]);
    if (pressure_pending && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_count <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [31:0] now, input logic [31:0] meas);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, now};
    do @(posedge clk); while (!in_tready);
    chk.note_sample(now, meas);
  endtask

  // Drop valid and wait until every result is back and the pipe is empty
  task automatic drain;
    in_tvalid <= 1'b0;
    while (chk.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Write all six registers plus one unused index, back to back
  task automatic load_trajectory(input logic [31:0] st, input logic [31:0] inv,
                                 input logic [31:0] rs, input logic [31:0] gain,
                                 input logic [31:0] init, input logic [31:0] change);
    logic [31:0] vals [6];
    logic [2:0]  idx;
    vals = '{st, inv, rs, gain, init, change};
    for (int i = 0; i < 7; i++) begin
      idx = (i < 6) ? 3'(i) : (unused_pick ? REG_UNUSED_HI : REG_UNUSED_LO);
      cfg_valid <= 1'b1;
      cfg_addr  <= idx;
      cfg_data  <= (i < 6) ? vals[i] : $urandom();
      do @(posedge clk); while (!cfg_ready);
      chk.set_reg(cfg_addr, cfg_data);
    end
    unused_pick = ~unused_pick;
    cfg_valid <= 1'b0;
  endtask

  // Pick a random trajectory; kind selects extremes or zero inverse duration
  task automatic choose_trajectory(input int kind);
    int unsigned dur;
    bit [63:0]   q;
    dur = ($urandom_range(9) == 0) ? $urandom_range(1, 60000) : $urandom_range(1, 4000);
    q = 64'h1_0000_0000 / dur;
    traj_start  = $urandom();
    traj_inv    = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    traj_rate   = (32'd30 << FRAC) / dur;
    traj_gain   = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 8 << FRAC);
    traj_init   = ($urandom_range(3) == 0) ? $urandom()
                                           : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    traj_change = ($urandom_range(3) == 0) ? $urandom()
                                           : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    traj_span   = dur + dur / 8 + 2;
    if (kind == 1) begin
      traj_inv    = 32'hFFFF_FFFF;
      traj_rate   = 32'hFFFF_FFFF;
      traj_gain   = 32'hFFFF_FFFF;
      traj_init   = 32'h7FFF_FFFF;
      traj_change = 32'h8000_0000;
      traj_span   = 3;
    end else if (kind == 2) begin
      traj_start = 32'd0;
      traj_inv   = 32'd0;
    end
    load_trajectory(traj_start, traj_inv, traj_rate, traj_gain, traj_init, traj_change);
  endtask

  // Random samples, mostly inside the trajectory window
  task automatic run_burst(input int count);
    logic [31:0] now, meas;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 80)
        now = traj_start + $urandom_range(0, traj_span);
      else if (pick < 90)
        now = $urandom();
      else
        now = traj_start - $urandom_range(1, 1000);
      meas = ($urandom_range(9) < 4) ? $urandom()
                                     : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      send_sample(now, meas);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, all registers zero
    send_idle_pct = 33;
    recv_idle_pct = 52;
    send_sample(32'd0, 32'd0);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000);
    drain();

    // Directed: 256-tick trajectory, tau from zero through one and past it
    load_trajectory(32'd1000, 32'h0100_0000, (32'd30 << FRAC) / 256, 32'h0001_0000,
                    32'h0002_0000, 32'hFFFC_0000);
    send_sample(32'd1000, 32'h0000_0000);
    send_sample(32'd1064, 32'h7FFF_FFFF);
    send_sample(32'd1128, 32'h8000_0000);
    send_sample(32'd1192, 32'h0001_8000);
    send_sample(32'd1256, 32'hFFFE_0000);
    send_sample(32'd1257, 32'h1234_5678);
    send_sample(32'd999, 32'h0000_0000);
    drain();

    // Directed: extreme registers, wrap across zero, saturation both ways
    load_trajectory(32'hFFFF_FFFF, 32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'd127, 32'h7FFF_FFFF);
    send_sample(32'd127, 32'h8000_0000);
    send_sample(32'd255, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000);
    drain();

    // Directed: zero inverse duration holds tau at zero
    load_trajectory(32'd0, 32'd0, 32'h0001_0000, 32'h0002_0000,
                    32'h0001_8000, 32'h0010_0000);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_0000);
    send_sample(32'h1234_5678, 32'h0003_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // Random bursts: sender and receiver both idle, long output stall once
    choose_trajectory(0);
    run_burst(SEG_ITEMS);
    choose_trajectory(0);
    pressure_pending = 1'b1;
    run_burst(SEG_ITEMS);

    // Swap the idle rates
    send_idle_pct = 52;
    recv_idle_pct = 33;
    choose_trajectory(0);
    run_burst(SEG_ITEMS);
    choose_trajectory(0);
    run_burst(SEG_ITEMS);

    // No idling, including extreme and zero inverse duration trajectories
    send_idle_pct = 0;
    recv_idle_pct = 0;
    choose_trajectory(1);
    run_burst(SEG_ITEMS);
    choose_trajectory(2);
    run_burst(SEG_ITEMS / 2);
    choose_trajectory(0);
    run_burst(SEG_ITEMS / 2);

    chk.close();
    if (chk.failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
